// ===== hw/rtl/mfuf_pkg.sv =====
// Package for the motor feedback unwrap filter.
// Holds the frame and result types, register indexes and angle constants.
// No dependencies.
package mfuf_pkg;

  localparam int unsigned ANGLE_RANGE = 8192;
  localparam int unsigned ANGLE_W     = $clog2(ANGLE_RANGE);
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned TURN_W      = TOTAL_W - ANGLE_W;
  localparam int unsigned FILT_W      = 24;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned GAIN_W      = 17;
  localparam int unsigned GAIN_FRAC_W = 16;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = GAIN_W;
  localparam int unsigned ID_MIN      = 1;
  localparam int unsigned ID_MAX      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ID   = 1'b0,
    REG_FILTER_GAIN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        [15:0] angle_word;
    logic signed [15:0] speed_word;
    logic signed [15:0] current_word;
    logic signed [7:0]  temperature_byte;
    logic        [31:0] arrival_tick;
  } in_item_t;

  typedef struct packed {
    logic                      accepted;
    logic [ANGLE_W-1:0]        angle_now;
    logic signed [TOTAL_W-1:0] unwrapped_angle;
    logic signed [15:0]        speed_now;
    logic signed [15:0]        current_now;
    logic signed [FILT_W-1:0]  current_smoothed;
    logic signed [7:0]         temperature_now;
  } out_item_t;

endpackage

// ===== hw/rtl/motor_feedback_unwrap_filter.sv =====
// Motor feedback unwrap filter: top level.
// Registers one feedback frame, unwraps the angle and filters the current.
// Depends on mfuf_pkg.
//
// One frame enters per clock while the output is not stalled; it is registered
// in s1_q and its snapshot then in the output register out_q. A frame is
// taken only if device_id is 1..8 and the angle word is below the angle range,
// otherwise the state holds and the snapshot shows accepted low. The first
// taken frame after reset, or after a frame with a zero tick, seeds the turn
// count and the filter. The per-frame loop is the filter update: one 18x25
// signed multiply and an add between the stored filter value and its update.
module motor_feedback_unwrap_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mfuf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mfuf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mfuf_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mfuf_pkg::out_item_t                 out_data_o
);

  localparam int unsigned AW = mfuf_pkg::ANGLE_W;
  localparam int unsigned TW = mfuf_pkg::TURN_W;
  localparam int unsigned FW = mfuf_pkg::FILT_W;
  localparam int unsigned GW = mfuf_pkg::GAIN_W;
  localparam int unsigned DW = FW + 1;
  localparam int unsigned PW = GW + 1 + DW;
  localparam logic signed [AW:0] HALF_POS = (AW+1)'(mfuf_pkg::ANGLE_RANGE / 2);
  localparam logic signed [AW:0] HALF_NEG = -HALF_POS;
  localparam logic [GW-1:0] GAIN_ONE = GW'(1 << mfuf_pkg::GAIN_FRAC_W);

  logic [mfuf_pkg::ID_W-1:0] device_id_q;
  logic [GW-1:0]             filter_gain_q;

  logic                s1_valid_q;
  mfuf_pkg::in_item_t  s1_q;
  logic                out_valid_q;
  mfuf_pkg::out_item_t out_q;

  logic                     seeded_q;
  logic [TW-1:0]            turn_q, turn_d;
  logic [AW-1:0]            angle_q;
  logic signed [15:0]       speed_q;
  logic signed [15:0]       current_q;
  logic signed [FW-1:0]     filt_q, filt_d;
  logic signed [7:0]        temp_q;

  logic out_ready, s1_ready, advance, ok;
  logic [AW-1:0]        angle_in;
  logic signed [AW:0]   delta;
  logic [GW-1:0]        gain_sat;
  logic signed [FW-1:0] cur_scaled;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  mfuf_pkg::out_item_t  result_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = !s1_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q   <= mfuf_pkg::ID_W'(1);
      filter_gain_q <= GW'(6554);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mfuf_pkg::REG_DEVICE_ID:   device_id_q   <= cfg_wdata_i[mfuf_pkg::ID_W-1:0];
        mfuf_pkg::REG_FILTER_GAIN: filter_gain_q <= cfg_wdata_i[GW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign angle_in = s1_q.angle_word[AW-1:0];
  assign ok = (device_id_q >= mfuf_pkg::ID_W'(mfuf_pkg::ID_MIN))
           && (device_id_q <= mfuf_pkg::ID_W'(mfuf_pkg::ID_MAX))
           && (s1_q.angle_word[15:AW] == '0);

  assign delta      = $signed({1'b0, angle_in}) - $signed({1'b0, angle_q});
  assign gain_sat   = filter_gain_q[GW-1] ? GAIN_ONE : filter_gain_q;
  assign cur_scaled = {s1_q.current_word, {mfuf_pkg::FRAC_W{1'b0}}};
  assign diff       = DW'(cur_scaled) - DW'(filt_q);
  assign prod       = $signed({1'b0, gain_sat}) * diff;

  always_comb begin
    turn_d = turn_q;
    filt_d = cur_scaled;
    if (seeded_q) begin
      priority if (delta > HALF_POS) begin
        turn_d = turn_q - TW'(1);
      end else if (delta < HALF_NEG) begin
        turn_d = turn_q + TW'(1);
      end else begin
        turn_d = turn_q;
      end
      filt_d = filt_q + prod[mfuf_pkg::GAIN_FRAC_W +: FW];
    end else begin
      turn_d = '0;
    end
  end

  always_comb begin
    result_d.accepted = ok;
    if (ok) begin
      result_d.angle_now        = angle_in;
      result_d.unwrapped_angle  = {turn_d, angle_in};
      result_d.speed_now        = s1_q.speed_word;
      result_d.current_now      = s1_q.current_word;
      result_d.current_smoothed = filt_d;
      result_d.temperature_now  = s1_q.temperature_byte;
    end else begin
      result_d.angle_now        = angle_q;
      result_d.unwrapped_angle  = {turn_q, angle_q};
      result_d.speed_now        = speed_q;
      result_d.current_now      = current_q;
      result_d.current_smoothed = filt_q;
      result_d.temperature_now  = temp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q  <= 1'b0;
      turn_q    <= '0;
      angle_q   <= '0;
      speed_q   <= '0;
      current_q <= '0;
      filt_q    <= '0;
      temp_q    <= '0;
    end else if (advance && ok) begin
      seeded_q  <= (s1_q.arrival_tick != '0);
      turn_q    <= turn_d;
      angle_q   <= angle_in;
      speed_q   <= s1_q.speed_word;
      current_q <= s1_q.current_word;
      filt_q    <= filt_d;
      temp_q    <= s1_q.temperature_byte;
    end
  end

endmodule

// ===== hw/rtl/mfuf_checker.sv =====
// Port-level checks for the motor feedback unwrap filter.
// Bound to motor_feedback_unwrap_filter; depends on mfuf_pkg.
module mfuf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input mfuf_pkg::out_item_t             out_data_o
);

  logic                seen_q;
  mfuf_pkg::out_item_t last_q;
  logic                out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (out_xfer) begin
      seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      last_q <= out_data_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_total_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.unwrapped_angle[mfuf_pkg::ANGLE_W-1:0] == out_data_o.angle_now)
    else $error("total angle does not end in the stored angle");

  a_reject_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_q && !out_data_o.accepted
      |-> out_data_o.angle_now == last_q.angle_now
       && out_data_o.unwrapped_angle == last_q.unwrapped_angle
       && out_data_o.speed_now == last_q.speed_now
       && out_data_o.current_now == last_q.current_now
       && out_data_o.current_smoothed == last_q.current_smoothed
       && out_data_o.temperature_now == last_q.temperature_now)
    else $error("rejected frame changed the snapshot");

  a_fresh_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted frame did not reach the output");

endmodule

bind motor_feedback_unwrap_filter mfuf_checker u_mfuf_checker (.*);

// ===== dv/mfuf_tb_pkg.sv =====
`timescale 1ns / 1ps
// Snapshot scoreboard for the motor feedback unwrap filter testbench.
// Predicts each snapshot from the taken frames and checks the block's output.
// Depends on mfuf_pkg.
package mfuf_tb_pkg;
  import mfuf_pkg::*;

  class snapshot_scoreboard;
    bit [ID_W-1:0]              dev_id;
    bit [GAIN_W-1:0]            gain;
    bit [ANGLE_W-1:0]           last_angle;
    bit [TURN_W-1:0]            turns;
    bit signed [TOTAL_W-1:0]    total;
    bit [ANGLE_W-1:0]           angle_q;
    bit signed [15:0]           speed_q;
    bit signed [15:0]           current_q;
    bit signed [FILT_W-1:0]     smooth_q;
    bit signed [7:0]            temp_q;
    bit [31:0]                  tick_q;
    out_item_t                  snapshots_due[$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                taken;
    int unsigned                dropped;
    int unsigned                turn_steps;

    function new();
      dev_id = 8'd1;
      gain   = 17'd6554;
    endfunction

    task complain(input string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function void note_frame(input in_item_t f);
      out_item_t snap;
      int        delta;
      longint    g;
      longint    unity;
      longint    mix;
      bit        ok;
      unity = longint'(1) <<< GAIN_FRAC_W;
      ok = dev_id >= ID_MIN && dev_id <= ID_MAX && f.angle_word < ANGLE_RANGE;
      if (ok) begin
        if (tick_q == '0) begin
          turns    = '0;
          smooth_q = FILT_W'(longint'($signed(f.current_word)) <<< FRAC_W);
        end else begin
          delta = int'(f.angle_word) - int'(last_angle);
          if (delta > int'(ANGLE_RANGE / 2)) begin
            turns = turns - 1'b1;
            turn_steps++;
          end else if (delta < -int'(ANGLE_RANGE / 2)) begin
            turns = turns + 1'b1;
            turn_steps++;
          end
          g = longint'(gain);
          if (g > unity) g = unity;
          mix = g * longint'($signed(f.current_word)) * (longint'(1) <<< FRAC_W)
              + (unity - g) * longint'(smooth_q);
          smooth_q = FILT_W'(mix >>> GAIN_FRAC_W);
        end
        total      = {turns, f.angle_word[ANGLE_W-1:0]};
        last_angle = f.angle_word[ANGLE_W-1:0];
        angle_q    = f.angle_word[ANGLE_W-1:0];
        speed_q    = f.speed_word;
        current_q  = f.current_word;
        temp_q     = f.temperature_byte;
        tick_q     = f.arrival_tick;
        taken++;
      end else begin
        dropped++;
      end
      snap.accepted         = ok;
      snap.angle_now        = angle_q;
      snap.unwrapped_angle  = total;
      snap.speed_now        = speed_q;
      snap.current_now      = current_q;
      snap.current_smoothed = smooth_q;
      snap.temperature_now  = temp_q;
      snapshots_due.push_back(snap);
    endfunction

    task diff(input string name, input logic [31:0] seen, input logic [31:0] due);
      if (seen !== due)
        complain($sformatf("snapshot %0d %s: got %h, expected %h", checked, name, seen, due));
    endtask

    task check_snapshot(input out_item_t got);
      out_item_t want;
      if (snapshots_due.size() == 0) begin
        complain($sformatf("snapshot %h arrived with none expected", got));
        return;
      end
      want = snapshots_due.pop_front();
      diff("accepted", got.accepted, want.accepted);
      diff("angle_now", got.angle_now, want.angle_now);
      diff("unwrapped_angle", got.unwrapped_angle, want.unwrapped_angle);
      diff("speed_now", got.speed_now, want.speed_now);
      diff("current_now", got.current_now, want.current_now);
      diff("current_smoothed", got.current_smoothed, want.current_smoothed);
      diff("temperature_now", got.temperature_now, want.temperature_now);
      checked++;
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the motor feedback unwrap filter testbench: clock, reset, drivers.
// Depends on mfuf_pkg, mfuf_tb_pkg and the motor_feedback_unwrap_filter RTL.
module tb_top;
  import mfuf_pkg::*;
  import mfuf_tb_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;

  snapshot_scoreboard    sb = new();
  bit                    calm;
  bit [ANGLE_W-1:0]      angle_cursor;
  int unsigned           settings;

  motor_feedback_unwrap_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Timed out with %0d snapshots outstanding", sb.snapshots_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_snapshot(out_data_o);
  end

  function automatic in_item_t feedback_frame(input logic [15:0] angle,
                                              input logic [15:0] speed,
                                              input logic [15:0] current,
                                              input logic [7:0] temp,
                                              input logic [31:0] tick);
    in_item_t f;
    f.angle_word       = angle;
    f.speed_word       = speed;
    f.current_word     = current;
    f.temperature_byte = temp;
    f.arrival_tick     = tick;
    return f;
  endfunction

  function automatic in_item_t random_frame(input bit onward);
    in_item_t    f;
    int unsigned pick;
    int          step;
    pick               = $urandom_range(0, 99);
    f.speed_word       = 16'($urandom);
    f.current_word     = 16'($urandom);
    if ($urandom_range(0, 4) == 0)
      f.current_word = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    f.temperature_byte = 8'($urandom);
    f.arrival_tick     = $urandom;
    if (pick < 75) begin
      if (pick < 60) begin
        step = $urandom_range(0, 2500);
        if ($urandom_range(0, 4) == 0) onward = !onward;
        if (!onward) step = -step;
      end else begin
        step = $urandom_range(ANGLE_RANGE / 2 - 200, ANGLE_RANGE / 2 + 200);
        if ($urandom_range(0, 1) == 0) step = -step;
      end
      f.angle_word = 16'((int'(angle_cursor) + step) & int'(ANGLE_RANGE - 1));
    end else if (pick < 85) begin
      f.angle_word = 16'($urandom_range(0, ANGLE_RANGE - 1));
    end else if (pick < 94) begin
      f.angle_word = 16'($urandom_range(ANGLE_RANGE, 16'hFFFF));
    end else begin
      f.angle_word   = 16'($urandom_range(0, ANGLE_RANGE - 1));
      f.arrival_tick = '0;
    end
    if (f.angle_word < ANGLE_RANGE) angle_cursor = f.angle_word[ANGLE_W-1:0];
    return f;
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_frame(input in_item_t f);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_frame(f);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_DEVICE_ID) sb.dev_id = val[ID_W-1:0];
    else sb.gain = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [ID_W-1:0] id, input logic [GAIN_W-1:0] g);
    in_valid_i <= 1'b0;
    while (sb.snapshots_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(REG_DEVICE_ID, CFG_DATA_W'(id));
    write_reg(REG_FILTER_GAIN, g);
    settings++;
  endtask

  initial begin
    int wait_cycles;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_DEVICE_ID;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: seeding, zero tick, half-turn boundaries, out-of-range angles
    send_frame(feedback_frame(16'd0, 16'd0, 16'd0, 8'd0, 32'd0));
    send_frame(feedback_frame(16'd8191, 16'h8000, 16'h8000, 8'h80, 32'hFFFF_FFFF));
    send_frame(feedback_frame(16'd0, 16'h7FFF, 16'h7FFF, 8'h7F, 32'd1));
    send_frame(feedback_frame(16'd8192, 16'd5, 16'd5, 8'd5, 32'd2));
    send_frame(feedback_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
    send_frame(feedback_frame(16'd4096, 16'd1, 16'h8000, 8'd1, 32'd3));
    send_frame(feedback_frame(16'd0, 16'd2, 16'h8000, 8'd2, 32'd4));
    send_frame(feedback_frame(16'd4097, 16'd3, 16'h7FFF, 8'd3, 32'd5));
    send_frame(feedback_frame(16'd0, 16'd4, 16'h7FFF, 8'd4, 32'd6));
    send_frame(feedback_frame(16'd100, 16'd5, 16'd300, 8'd5, 32'd0));
    send_frame(feedback_frame(16'd5000, 16'd6, 16'h8000, 8'd6, 32'd7));
    send_frame(feedback_frame(16'd5000, 16'd7, 16'h7FFF, 8'd7, 32'd8));

    // device ids outside 1..8 drop every frame; id 8 at the edge is taken
    set_config(8'd0, 17'd6554);
    send_frame(feedback_frame(16'd10, 16'd1, 16'd1, 8'd1, 32'd9));
    set_config(8'd9, 17'd6554);
    send_frame(feedback_frame(16'd20, 16'd1, 16'd1, 8'd1, 32'd10));
    set_config(8'd255, 17'd6554);
    send_frame(feedback_frame(16'd30, 16'd1, 16'd1, 8'd1, 32'd11));
    set_config(8'd8, 17'd6554);
    send_frame(feedback_frame(16'd40, 16'd1, 16'd1000, 8'd1, 32'd12));

    // gain extremes: hold, pass-through, saturation above one
    set_config(8'd8, 17'd0);
    send_frame(feedback_frame(16'd50, 16'd2, 16'h7FFF, 8'd2, 32'd13));
    send_frame(feedback_frame(16'd60, 16'd2, 16'h8000, 8'd2, 32'd14));
    set_config(8'd1, 17'd65536);
    send_frame(feedback_frame(16'd70, 16'd3, 16'h8000, 8'd3, 32'd15));
    send_frame(feedback_frame(16'd80, 16'd3, 16'd1234, 8'd3, 32'd16));
    set_config(8'd2, 17'h1FFFF);
    send_frame(feedback_frame(16'd90, 16'd4, 16'h7FFF, 8'd4, 32'd17));
    send_frame(feedback_frame(16'd8000, 16'd4, 16'hFFFF, 8'd4, 32'd18));
    set_config(8'd7, 17'd1);
    send_frame(feedback_frame(16'd100, 16'd5, 16'h8000, 8'd5, 32'd19));

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_config(8'd1, 17'd6554);
        1: set_config(8'd8, 17'd65536);
        2: set_config(8'($urandom_range(ID_MIN, ID_MAX)), 17'($urandom_range(0, 1000)));
        3: set_config(8'd4, 17'h1FFFF);
        default: begin
          set_config(8'($urandom_range(ID_MIN, ID_MAX)), 17'($urandom_range(0, 17'h1FFFF)));
          calm = 1'b1;
        end
      endcase
      for (int n = 0; n < 190; n++) send_frame(random_frame(p % 2 == 0));
    end

    in_valid_i <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 2000 && sb.snapshots_due.size() != 0; wait_cycles++)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (sb.snapshots_due.size() != 0)
      sb.complain($sformatf("%0d snapshots never arrived", sb.snapshots_due.size()));

    $display("Sent %0d frames (%0d taken, %0d dropped) with %0d turn steps",
             sb.taken + sb.dropped, sb.taken, sb.dropped, sb.turn_steps);
    $display("Checked %0d snapshots over %0d register settings, %0d mismatches",
             sb.checked, settings + 1, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
